@@ rtl/rvb_pkg.sv @@
// ----------------------------------------------------------------------------
// rvb_pkg
// Shared widths, constants and register indexes of the radial vignette blend.
// ----------------------------------------------------------------------------
package rvb_pkg;

  localparam int FRAME_DIM_MAX_DEF = 4096;

  localparam int PIX_W      = 12;
  localparam int CH_W       = 8;
  localparam int RGB_W      = 3 * CH_W;
  localparam int FRAC_W     = 16;
  localparam int PCT_W      = 8;
  localparam int SOFT_W     = 7;
  localparam int DIM_W      = 13;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // center in Q.16 pixels, doubled offset, vertical divisor
  localparam int CXY_W = FRAC_W + DIM_W;
  localparam int NX_W  = CXY_W + 1;
  localparam int DYD_W = DIM_W + 8;
  localparam int NY_W  = NX_W + 7;

  // distance, Q4.16
  localparam int DIST_W = 20;
  localparam int ROOT_W = DIST_W + 1;
  localparam int RAD_W  = 2 * ROOT_W;
  localparam int SQ_W   = 2 * DIST_W;

  // softness ramp
  localparam int POS_W  = 30;
  localparam int RDEN_W = 10;
  localparam int WQ_W   = 16;
  localparam int W_W    = WQ_W + 1;

  // amount scaling: floor(t / 100) = (t * RECIP) >> RECIP_SH for t < 2^23
  localparam int AMT_W    = 7;
  localparam int TPROD_W  = 23;
  localparam int RECIP_W  = 24;
  localparam int RECIP_SH = 30;
  localparam logic [RECIP_W-1:0] RECIP = 24'd10737419;

  localparam int BL_W = CH_W + W_W;

  localparam logic [DIST_W-1:0] DIST_MAX = '1;
  localparam logic [W_W-1:0]    ONE_Q16  = 17'h10000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_X  = 3'd0,
    REG_CENTER_Y  = 3'd1,
    REG_AMOUNT    = 3'd2,
    REG_ROUNDNESS = 3'd3,
    REG_SOFTNESS  = 3'd4,
    REG_TINT      = 3'd5,
    REG_WIDTH     = 3'd6,
    REG_HEIGHT    = 3'd7
  } cfg_reg_t;

endpackage

@@ rtl/radial_vignette_blend_unit.sv @@
// ----------------------------------------------------------------------------
// radial_vignette_blend_unit
// Blends each pixel toward a tint by a weight from its elliptical distance
// to a configurable center, through a softness ramp and an amount curve.
// ----------------------------------------------------------------------------
//  channel   signals                                   direction
//  in        in_valid/in_ready, pixel_x/y, *_in        request in
//  out       out_valid/out_ready, red/green/blue_out   request out
//  cfg       cfg_write, cfg_index, cfg_data            register write
//
//  One request per clock; 73 register stages, the last of them drives out_valid.
//  Most of the depth is in the two 20-step offset dividers side by side,
//  then the 21-step square root and the 16-step ramp divider.
//  All stages advance together; when out_valid is held without out_ready the
//  whole pipe stops and in_ready drops, nothing is dropped or repeated.
//  Synchronous reset clears valid bits and loads register defaults.
// ----------------------------------------------------------------------------
module radial_vignette_blend_unit
  import rvb_pkg::*;
#(
  parameter int FRAME_DIM_MAX = FRAME_DIM_MAX_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [PIX_W-1:0]      pixel_x,
  input  logic [PIX_W-1:0]      pixel_y,
  input  logic [CH_W-1:0]       red_in,
  input  logic [CH_W-1:0]       green_in,
  input  logic [CH_W-1:0]       blue_in,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [CH_W-1:0]       red_out,
  output logic [CH_W-1:0]       green_out,
  output logic [CH_W-1:0]       blue_out,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int DIM_LIM = (1 << DIM_W) - 1;
  localparam int DIM_CAP = (FRAME_DIM_MAX > DIM_LIM) ? DIM_LIM : FRAME_DIM_MAX;

  // ---------------- configuration registers ----------------
  logic [FRAC_W-1:0]       center_x_frac;
  logic [FRAC_W-1:0]       center_y_frac;
  logic signed [PCT_W-1:0] amount_pct;
  logic signed [PCT_W-1:0] roundness_pct;
  logic [SOFT_W-1:0]       softness_pct;
  logic [RGB_W-1:0]        tint_rgb;
  logic [DIM_W-1:0]        frame_width;
  logic [DIM_W-1:0]        frame_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x_frac <= 16'd32768;
      center_y_frac <= 16'd32768;
      amount_pct    <= -8'sd50;
      roundness_pct <= 8'sd0;
      softness_pct  <= 7'd50;
      tint_rgb      <= '0;
      frame_width   <= 13'd1920;
      frame_height  <= 13'd1080;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_CENTER_X:  center_x_frac <= cfg_data[FRAC_W-1:0];
        REG_CENTER_Y:  center_y_frac <= cfg_data[FRAC_W-1:0];
        REG_AMOUNT:    amount_pct    <= cfg_data[PCT_W-1:0];
        REG_ROUNDNESS: roundness_pct <= cfg_data[PCT_W-1:0];
        REG_SOFTNESS:  softness_pct  <= cfg_data[SOFT_W-1:0];
        REG_TINT:      tint_rgb      <= cfg_data[RGB_W-1:0];
        REG_WIDTH:     frame_width   <= cfg_data[DIM_W-1:0];
        REG_HEIGHT:    frame_height  <= cfg_data[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- derived settings, refreshed every cycle ----------------
  logic [DIM_W-1:0]        w_dim_c, h_dim_c;
  logic signed [PCT_W-1:0] amt_c, rnd_c;
  logic signed [PCT_W:0]   rsum_c;
  logic [SOFT_W-1:0]       soft_c;

  logic [DIM_W-1:0]        w_dim;
  logic [CXY_W-1:0]        cx, cy;
  logic [DYD_W-1:0]        dy_den;
  logic signed [PCT_W-1:0] amt;
  logic                    flat;
  logic [RDEN_W-1:0]       ramp_den;
  logic [RDEN_W-1:0]       ramp_neg;

  always_comb begin
    if (frame_width == '0) w_dim_c = DIM_W'(1);
    else if ({1'b0, frame_width} > (DIM_W+1)'(DIM_CAP)) w_dim_c = DIM_W'(DIM_CAP);
    else w_dim_c = frame_width;
    if (frame_height == '0) h_dim_c = DIM_W'(1);
    else if ({1'b0, frame_height} > (DIM_W+1)'(DIM_CAP)) h_dim_c = DIM_W'(DIM_CAP);
    else h_dim_c = frame_height;
    if (amount_pct < -8'sd100) amt_c = -8'sd100;
    else if (amount_pct > 8'sd100) amt_c = 8'sd100;
    else amt_c = amount_pct;
    if (roundness_pct < -8'sd100) rnd_c = -8'sd100;
    else if (roundness_pct > 8'sd100) rnd_c = 8'sd100;
    else rnd_c = roundness_pct;
    rsum_c = 9'sd100 + {rnd_c[PCT_W-1], rnd_c};
    soft_c = (softness_pct > 7'd100) ? 7'd100 : softness_pct;
  end

  always_ff @(posedge clk) begin
    w_dim    <= w_dim_c;
    cx       <= CXY_W'(center_x_frac * w_dim_c);
    cy       <= CXY_W'(center_y_frac * h_dim_c);
    dy_den   <= DYD_W'(h_dim_c * rsum_c[PCT_W-1:0]);
    amt      <= amt_c;
    flat     <= (rnd_c == -8'sd100);
    ramp_den <= RDEN_W'(soft_c) * 10'd10 + 10'd1;
    ramp_neg <= 10'd1000 - RDEN_W'(soft_c) * 10'd10;
  end

  // ---------------- pipeline control ----------------
  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en && !rst;

  // s1: capture request
  logic             v1;
  logic [PIX_W-1:0] px1, py1;
  logic [RGB_W-1:0] rgb1;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px1  <= pixel_x;
      py1  <= pixel_y;
      rgb1 <= {red_in, green_in, blue_in};
    end
  end

  // s2: doubled offset from center
  logic              v2;
  logic [NX_W-1:0]   nx2, oy2;
  logic [RGB_W-1:0]  rgb2;
  logic [CXY_W:0]    sx_c, sy_c;
  logic [CXY_W-1:0]  ax_c, ay_c;

  always_comb begin
    sx_c = {1'b0, CXY_W'({px1, FRAC_W'(0)})} - {1'b0, cx};
    sy_c = {1'b0, CXY_W'({py1, FRAC_W'(0)})} - {1'b0, cy};
    ax_c = sx_c[CXY_W] ? CXY_W'(-sx_c) : sx_c[CXY_W-1:0];
    ay_c = sy_c[CXY_W] ? CXY_W'(-sy_c) : sy_c[CXY_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nx2  <= {ax_c, 1'b0};
      oy2  <= {ay_c, 1'b0};
      rgb2 <= rgb1;
    end
  end

  // s3: vertical numerator, horizontal overflow
  logic             v3, sat_x3;
  logic [NX_W-1:0]  nx3;
  logic [NY_W-1:0]  ny3;
  logic [RGB_W-1:0] rgb3;

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (en) v3 <= v2;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nx3    <= nx2;
      ny3    <= NY_W'(oy2 * 7'd100);
      sat_x3 <= {3'b0, nx2} >= {w_dim, DIST_W'(0)};
      rgb3   <= rgb2;
    end
  end

  // s4: vertical overflow
  logic             v4, sat_x4, sat_y4;
  logic [NX_W-1:0]  nx4;
  logic [NY_W-1:0]  ny4;
  logic [RGB_W-1:0] rgb4;

  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (en) v4 <= v3;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nx4    <= nx3;
      ny4    <= ny3;
      sat_x4 <= sat_x3;
      sat_y4 <= {4'b0, ny3} >= {dy_den, DIST_W'(0)};
      rgb4   <= rgb3;
    end
  end

  // offset dividers
  logic              vdx;
  logic [DIST_W-1:0] qx, qy;
  logic [RGB_W:0]    side_x;
  logic              side_y;
  logic              vdy_unused;

  rvb_div_pipe #(
    .NUM_W (NX_W),
    .DEN_W (DIM_W),
    .Q_W   (DIST_W),
    .SIDE_W(RGB_W + 1)
  ) u_div_x (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (v4),
    .num      (nx4),
    .den      (w_dim),
    .side_in  ({rgb4, sat_x4}),
    .out_valid(vdx),
    .quot     (qx),
    .side_out (side_x)
  );

  rvb_div_pipe #(
    .NUM_W (NY_W),
    .DEN_W (DYD_W),
    .Q_W   (DIST_W),
    .SIDE_W(1)
  ) u_div_y (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (v4),
    .num      (ny4),
    .den      (dy_den),
    .side_in  (sat_y4),
    .out_valid(vdy_unused),
    .quot     (qy),
    .side_out (side_y)
  );

  // s5: clamp and square
  logic              v5;
  logic [SQ_W-1:0]   dx2_5, dy2_5;
  logic [RGB_W-1:0]  rgb5;
  logic [DIST_W-1:0] dx_c, dy_c;

  assign dx_c = side_x[0] ? DIST_MAX : qx;
  assign dy_c = side_y    ? DIST_MAX : qy;

  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else if (en) v5 <= vdx && !vdy_unused ? 1'b0 : vdx;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx2_5 <= dx_c * dx_c;
      dy2_5 <= dy_c * dy_c;
      rgb5  <= side_x[RGB_W:1];
    end
  end

  // s6: sum of squares
  logic             v6;
  logic [SQ_W:0]    sum6;
  logic [RGB_W-1:0] rgb6;

  always_ff @(posedge clk) begin
    if (rst) v6 <= 1'b0;
    else if (en) v6 <= v5;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum6 <= {1'b0, dx2_5} + {1'b0, dy2_5};
      rgb6 <= rgb5;
    end
  end

  logic              vsq;
  logic [ROOT_W-1:0] root;
  logic [RGB_W-1:0]  rgb_sq;

  rvb_sqrt_pipe #(
    .ROOT_W(ROOT_W),
    .SIDE_W(RGB_W)
  ) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (v6),
    .radicand (RAD_W'(sum6)),
    .side_in  (rgb6),
    .out_valid(vsq),
    .root     (root),
    .side_out (rgb_sq)
  );

  // s7: clamp distance, scale by 1000
  logic              v7;
  logic [POS_W-1:0]  pos7;
  logic [RGB_W-1:0]  rgb7;
  logic [DIST_W-1:0] dist_c;

  assign dist_c = (root > {1'b0, DIST_MAX}) ? DIST_MAX : root[DIST_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) v7 <= 1'b0;
    else if (en) v7 <= vsq;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pos7 <= POS_W'(dist_c * 10'd1000);
      rgb7 <= rgb_sq;
    end
  end

  // s8: ramp offset
  logic             v8, le8;
  logic [POS_W-1:0] diff8;
  logic [RGB_W-1:0] rgb8;

  always_ff @(posedge clk) begin
    if (rst) v8 <= 1'b0;
    else if (en) v8 <= v7;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      le8   <= pos7 <= POS_W'({ramp_neg, WQ_W'(0)});
      diff8 <= pos7 - POS_W'({ramp_neg, WQ_W'(0)});
      rgb8  <= rgb7;
    end
  end

  // s9: ramp overflow
  logic             v9, le9, sat9;
  logic [POS_W-1:0] diff9;
  logic [RGB_W-1:0] rgb9;

  always_ff @(posedge clk) begin
    if (rst) v9 <= 1'b0;
    else if (en) v9 <= v8;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      le9   <= le8;
      sat9  <= diff8 >= POS_W'({ramp_den, WQ_W'(0)});
      diff9 <= diff8;
      rgb9  <= rgb8;
    end
  end

  logic            vrp;
  logic [WQ_W-1:0] qr;
  logic [RGB_W+1:0] side_r;

  rvb_div_pipe #(
    .NUM_W (POS_W),
    .DEN_W (RDEN_W),
    .Q_W   (WQ_W),
    .SIDE_W(RGB_W + 2)
  ) u_div_ramp (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (v9),
    .num      (diff9),
    .den      (ramp_den),
    .side_in  ({rgb9, le9, sat9}),
    .out_valid(vrp),
    .quot     (qr),
    .side_out (side_r)
  );

  // s10: ramp weight; below the ramp the wrapped difference looks saturated
  logic             v10;
  logic [W_W-1:0]   w10;
  logic [RGB_W-1:0] rgb10;

  always_ff @(posedge clk) begin
    if (rst) v10 <= 1'b0;
    else if (en) v10 <= vrp;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (flat)           w10 <= ONE_Q16;
      else if (side_r[1]) w10 <= '0;
      else if (side_r[0]) w10 <= ONE_Q16;
      else                w10 <= {1'b0, qr};
      rgb10 <= side_r[RGB_W+1:2];
    end
  end

  // s11: amount operand
  logic             v11;
  logic [W_W-1:0]   m11;
  logic [AMT_W-1:0] mag11;
  logic [RGB_W-1:0] rgb11;

  always_ff @(posedge clk) begin
    if (rst) v11 <= 1'b0;
    else if (en) v11 <= v10;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m11   <= amt[PCT_W-1] ? w10 : ONE_Q16 - w10;
      mag11 <= AMT_W'(amt[PCT_W-1] ? -amt : amt);
      rgb11 <= rgb10;
    end
  end

  // s12: scale by percent
  logic               v12;
  logic [TPROD_W-1:0] t12;
  logic [RGB_W-1:0]   rgb12;

  always_ff @(posedge clk) begin
    if (rst) v12 <= 1'b0;
    else if (en) v12 <= v11;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t12   <= TPROD_W'(m11 * mag11);
      rgb12 <= rgb11;
    end
  end

  // s13: divide by 100 through reciprocal
  logic                       v13;
  logic [W_W-1:0]             q13;
  logic [RGB_W-1:0]           rgb13;
  logic [TPROD_W+RECIP_W-1:0] rp_c;

  assign rp_c = t12 * RECIP;

  always_ff @(posedge clk) begin
    if (rst) v13 <= 1'b0;
    else if (en) v13 <= v12;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q13   <= W_W'(rp_c >> RECIP_SH);
      rgb13 <= rgb12;
    end
  end

  // s14: final weight
  logic             v14;
  logic [W_W-1:0]   wf14;
  logic [RGB_W-1:0] rgb14;

  always_ff @(posedge clk) begin
    if (rst) v14 <= 1'b0;
    else if (en) v14 <= v13;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      wf14  <= amt[PCT_W-1] ? q13 : ONE_Q16 - q13;
      rgb14 <= rgb13;
    end
  end

  // s15: blend products
  logic            v15;
  logic [BL_W-1:0] pr_in [3];
  logic [BL_W-1:0] pr_tn [3];
  logic [W_W-1:0]  inv_c;

  assign inv_c = ONE_Q16 - wf14;

  always_ff @(posedge clk) begin
    if (rst) v15 <= 1'b0;
    else if (en) v15 <= v14;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        pr_in[c] <= rgb14[RGB_W-1-c*CH_W -: CH_W] * inv_c;
        pr_tn[c] <= tint_rgb[RGB_W-1-c*CH_W -: CH_W] * wf14;
      end
    end
  end

  // s16: sum, truncate, saturate into output register
  logic [BL_W-WQ_W:0] ch_c [3];
  logic [CH_W-1:0]    sat_c [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      ch_c[c]  = (BL_W-WQ_W+1)'(({1'b0, pr_in[c]} + {1'b0, pr_tn[c]}) >> WQ_W);
      sat_c[c] = (ch_c[c] > (BL_W-WQ_W+1)'(255)) ? 8'hFF : ch_c[c][CH_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= v15;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      red_out   <= sat_c[0];
      green_out <= sat_c[1];
      blue_out  <= sat_c[2];
    end
  end

endmodule

@@ rtl/rvb_div_pipe.sv @@
// ----------------------------------------------------------------------------
// rvb_div_pipe
// Pipelined restoring divider, one quotient bit per stage, with side bus.
// Expects num < den * 2^Q_W; the caller flags and overrides other cases.
// ----------------------------------------------------------------------------
module rvb_div_pipe #(
  parameter int NUM_W  = 30,
  parameter int DEN_W  = 13,
  parameter int Q_W    = 20,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [NUM_W-1:0]  num,
  input  logic [DEN_W-1:0]  den,
  input  logic [SIDE_W-1:0] side_in,
  output logic              out_valid,
  output logic [Q_W-1:0]    quot,
  output logic [SIDE_W-1:0] side_out
);

  logic              vld      [Q_W];
  logic [DEN_W-1:0]  rem      [Q_W];
  logic [Q_W-1:0]    lq       [Q_W];
  logic [SIDE_W-1:0] sd       [Q_W];

  logic              vld_src  [Q_W];
  logic [DEN_W-1:0]  rem_src  [Q_W];
  logic [Q_W-1:0]    lq_src   [Q_W];
  logic [SIDE_W-1:0] sd_src   [Q_W];
  logic [DEN_W-1:0]  rem_next [Q_W];
  logic [Q_W-1:0]    lq_next  [Q_W];

  always_comb begin
    vld_src[0] = in_valid;
    rem_src[0] = DEN_W'(num >> Q_W);
    lq_src[0]  = num[Q_W-1:0];
    sd_src[0]  = side_in;
    for (int s = 1; s < Q_W; s++) begin
      vld_src[s] = vld[s-1];
      rem_src[s] = rem[s-1];
      lq_src[s]  = lq[s-1];
      sd_src[s]  = sd[s-1];
    end
  end

  // bring down the next dividend bit, subtract when it fits
  always_comb begin
    for (int s = 0; s < Q_W; s++) begin
      logic [DEN_W:0] trial;
      logic           fit;
      trial       = {rem_src[s], lq_src[s][Q_W-1]};
      fit         = trial >= {1'b0, den};
      rem_next[s] = fit ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
      lq_next[s]  = {lq_src[s][Q_W-2:0], fit};
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < Q_W; s++) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (en) begin
        vld[s] <= vld_src[s];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < Q_W; s++) begin
        rem[s] <= rem_next[s];
        lq[s]  <= lq_next[s];
        sd[s]  <= sd_src[s];
      end
    end
  end

  assign out_valid = vld[Q_W-1];
  assign quot      = lq[Q_W-1];
  assign side_out  = sd[Q_W-1];

endmodule

@@ rtl/rvb_sqrt_pipe.sv @@
// ----------------------------------------------------------------------------
// rvb_sqrt_pipe
// Pipelined integer square root, one root bit per stage, with side bus.
// ----------------------------------------------------------------------------
module rvb_sqrt_pipe #(
  parameter int ROOT_W = 21,
  parameter int SIDE_W = 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic [2*ROOT_W-1:0] radicand,
  input  logic [SIDE_W-1:0]   side_in,
  output logic                out_valid,
  output logic [ROOT_W-1:0]   root,
  output logic [SIDE_W-1:0]   side_out
);

  localparam int RAD_W = 2 * ROOT_W;
  localparam int REM_W = ROOT_W + 2;

  logic              vld       [ROOT_W];
  logic [REM_W-1:0]  rem       [ROOT_W];
  logic [ROOT_W-1:0] rt        [ROOT_W];
  logic [RAD_W-1:0]  rad       [ROOT_W];
  logic [SIDE_W-1:0] sd        [ROOT_W];

  logic              vld_src   [ROOT_W];
  logic [REM_W-1:0]  rem_src   [ROOT_W];
  logic [ROOT_W-1:0] rt_src    [ROOT_W];
  logic [RAD_W-1:0]  rad_src   [ROOT_W];
  logic [SIDE_W-1:0] sd_src    [ROOT_W];
  logic [REM_W-1:0]  rem_next  [ROOT_W];
  logic [ROOT_W-1:0] rt_next   [ROOT_W];

  always_comb begin
    vld_src[0] = in_valid;
    rem_src[0] = '0;
    rt_src[0]  = '0;
    rad_src[0] = radicand;
    sd_src[0]  = side_in;
    for (int s = 1; s < ROOT_W; s++) begin
      vld_src[s] = vld[s-1];
      rem_src[s] = rem[s-1];
      rt_src[s]  = rt[s-1];
      rad_src[s] = rad[s-1];
      sd_src[s]  = sd[s-1];
    end
  end

  // take two radicand bits, try (root << 2) | 1
  always_comb begin
    for (int s = 0; s < ROOT_W; s++) begin
      logic [REM_W+1:0] cur;
      logic [REM_W+1:0] trial;
      logic             fit;
      cur         = {rem_src[s], rad_src[s][RAD_W-1 -: 2]};
      trial       = (REM_W+2)'({rt_src[s], 2'b01});
      fit         = cur >= trial;
      rem_next[s] = fit ? REM_W'(cur - trial) : REM_W'(cur);
      rt_next[s]  = {rt_src[s][ROOT_W-2:0], fit};
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < ROOT_W; s++) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (en) begin
        vld[s] <= vld_src[s];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < ROOT_W; s++) begin
        rem[s] <= rem_next[s];
        rt[s]  <= rt_next[s];
        rad[s] <= rad_src[s] << 2;
        sd[s]  <= sd_src[s];
      end
    end
  end

  assign out_valid = vld[ROOT_W-1];
  assign root      = rt[ROOT_W-1];
  assign side_out  = sd[ROOT_W-1];

endmodule

@@ test/radial_vignette_blend_unit_test.sv @@
// ----------------------------------------------------------------------------
// radial_vignette_blend_unit_test
// Streams pixels through the vignette blend under several register settings,
// with bursty input and a stalling output, and checks every blended pixel
// against a bit-exact prediction kept in order.
// ----------------------------------------------------------------------------
module radial_vignette_blend_unit_test;
  import rvb_pkg::*;

  typedef struct packed {
    logic [PIX_W-1:0] x;
    logic [PIX_W-1:0] y;
    logic [CH_W-1:0]  r;
    logic [CH_W-1:0]  g;
    logic [CH_W-1:0]  b;
  } pixel_t;

  typedef struct packed {
    logic [CH_W-1:0] r;
    logic [CH_W-1:0] g;
    logic [CH_W-1:0] b;
  } rgb_t;

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_ready;
  logic [PIX_W-1:0]      pixel_x;
  logic [PIX_W-1:0]      pixel_y;
  logic [CH_W-1:0]       red_in;
  logic [CH_W-1:0]       green_in;
  logic [CH_W-1:0]       blue_in;
  logic                  out_valid;
  logic                  out_ready;
  logic [CH_W-1:0]       red_out;
  logic [CH_W-1:0]       green_out;
  logic [CH_W-1:0]       blue_out;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  radial_vignette_blend_unit dut (.*);

  // shadow copy of the block's registers
  logic [FRAC_W-1:0] cen_x, cen_y;
  logic [PCT_W-1:0]  amount, roundness;
  logic [SOFT_W-1:0] softness;
  logic [RGB_W-1:0]  tint;
  logic [DIM_W-1:0]  width, height;

  pixel_t pending_pixels[$];
  rgb_t   expected_rgb[$];
  int     errors = 0;
  int     burst_left = 0;
  int     gap_left = 0;
  int     stall_mode = 0;
  int     stall_left = 0;
  logic   cfg_busy = 1;

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  function automatic longint unsigned root64(longint unsigned v);
    longint unsigned r, bit_;
    r = 0;
    bit_ = 64'd1 << 62;
    while (bit_ > v) bit_ >>= 2;
    while (bit_ != 0) begin
      if (v >= r + bit_) begin
        v -= r + bit_;
        r = (r >> 1) + bit_;
      end else begin
        r >>= 1;
      end
      bit_ >>= 2;
    end
    return r;
  endfunction

  function automatic longint unsigned dim_hold(logic [DIM_W-1:0] d);
    if (d < 1) return 1;
    if (d > FRAME_DIM_MAX_DEF) return FRAME_DIM_MAX_DEF;
    return d;
  endfunction

  function automatic int pct_hold(logic [PCT_W-1:0] v);
    int s;
    s = $signed(v);
    if (s < -100) return -100;
    if (s > 100) return 100;
    return s;
  endfunction

  function automatic longint unsigned offset2(longint unsigned p, longint unsigned frac,
                                              longint unsigned dim);
    longint unsigned a, c;
    a = p << 16;
    c = frac * dim;
    return 2 * (a >= c ? a - c : c - a);
  endfunction

  function automatic logic [CH_W-1:0] mix(logic [CH_W-1:0] in_c, logic [CH_W-1:0] t_c,
                                          longint unsigned w);
    longint unsigned v;
    v = (longint'(in_c) * (65536 - w) + longint'(t_c) * w) >> 16;
    return v > 255 ? 8'd255 : v[7:0];
  endfunction

  function automatic rgb_t vignette_pixel(pixel_t p);
    longint unsigned wd, hd, soft_lim, w, dx, dy, dist_q, pos, neg;
    int amt, rnd;
    rgb_t o;
    wd = dim_hold(width);
    hd = dim_hold(height);
    amt = pct_hold(amount);
    rnd = pct_hold(roundness);
    soft_lim = softness > 100 ? 100 : softness;
    if (rnd == -100) begin
      w = 65536;
    end else begin
      dx = offset2(p.x, cen_x, wd) / wd;
      dy = offset2(p.y, cen_y, hd) * 100 / (hd * longint'(100 + rnd));
      if (dx > DIST_MAX) dx = DIST_MAX;
      if (dy > DIST_MAX) dy = DIST_MAX;
      dist_q = root64(dx * dx + dy * dy);
      if (dist_q > DIST_MAX) dist_q = DIST_MAX;
      pos = 1000 * dist_q;
      neg = (1000 - 10 * soft_lim) << 16;
      if (pos <= neg) w = 0;
      else begin
        w = (pos - neg) / (10 * soft_lim + 1);
        if (w > 65536) w = 65536;
      end
    end
    if (amt < 0) w = w * longint'(-amt) / 100;
    else w = 65536 - (65536 - w) * longint'(amt) / 100;
    o.r = mix(p.r, tint[23:16], w);
    o.g = mix(p.g, tint[15:8], w);
    o.b = mix(p.b, tint[7:0], w);
    return o;
  endfunction

  task automatic report(string what, rgb_t got, rgb_t want);
    $display("error: %s got %h/%h/%h want %h/%h/%h", what, got.r, got.g, got.b,
             want.r, want.g, want.b);
    errors++;
  endtask

  // driver: bursts with random gaps
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        expected_rgb.push_back(vignette_pixel({pixel_x, pixel_y, red_in, green_in, blue_in}));
        void'(pending_pixels.pop_front());
      end
      if (in_valid && !in_ready) begin
        // hold
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 0;
      end else if (pending_pixels.size() > 0 && !cfg_busy) begin
        pixel_x  <= pending_pixels[0].x;
        pixel_y  <= pending_pixels[0].y;
        red_in   <= pending_pixels[0].r;
        green_in <= pending_pixels[0].g;
        blue_in  <= pending_pixels[0].b;
        in_valid <= 1;
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 40);
          if ($urandom_range(0, 2) != 0) gap_left <= $urandom_range(0, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 0;
      end
    end
  end

  // receiver stall pattern and checker
  always @(posedge clk) begin
    rgb_t got, want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        got = '{red_out, green_out, blue_out};
        if (expected_rgb.size() == 0) begin
          report("unexpected pixel", got, got);
        end else begin
          want = expected_rgb.pop_front();
          if (got.r !== want.r) report("red", got, want);
          else if (got.g !== want.g) report("green", got, want);
          else if (got.b !== want.b) report("blue", got, want);
        end
      end
      if (stall_left == 0) begin
        stall_mode <= $urandom_range(0, 3);
        stall_left <= $urandom_range(5, 60);
      end else begin
        stall_left <= stall_left - 1;
      end
      case (stall_mode)
        0: out_ready <= 1;
        1: out_ready <= $urandom_range(0, 1);
        2: out_ready <= ($urandom_range(0, 7) != 0);
        default: out_ready <= ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  task automatic write_reg(cfg_reg_t idx, int unsigned val);
    @(posedge clk);
    cfg_write <= 1;
    cfg_index <= idx;
    cfg_data  <= val[CFG_DATA_W-1:0];
    case (idx)
      REG_CENTER_X:  cen_x = val[15:0];
      REG_CENTER_Y:  cen_y = val[15:0];
      REG_AMOUNT:    amount = val[7:0];
      REG_ROUNDNESS: roundness = val[7:0];
      REG_SOFTNESS:  softness = val[6:0];
      REG_TINT:      tint = val[23:0];
      REG_WIDTH:     width = val[12:0];
      default:       height = val[12:0];
    endcase
    @(posedge clk);
    cfg_write <= 0;
  endtask

  // wait until the pipe has drained
  task automatic drain();
    while (pending_pixels.size() != 0 || in_valid || expected_rgb.size() != 0) begin
      @(posedge clk);
    end
    repeat (100) @(posedge clk);
  endtask

  task automatic add_pixel(int x, int y, int r, int g, int b);
    pixel_t p;
    p.x = PIX_W'(x);
    p.y = PIX_W'(y);
    p.r = CH_W'(r);
    p.g = CH_W'(g);
    p.b = CH_W'(b);
    pending_pixels.push_back(p);
  endtask

  task automatic add_random(int n, int w, int h);
    repeat (n) begin
      if ($urandom_range(0, 9) == 0)
        add_pixel($urandom_range(0, 4095), $urandom_range(0, 4095),
                  $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
      else
        add_pixel($urandom_range(0, w - 1), $urandom_range(0, h - 1),
                  $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
    end
  endtask

  task automatic run_phase();
    cfg_busy = 0;
    drain();
    cfg_busy = 1;
  endtask

  initial begin
    int w, h;
    rst = 1;
    in_valid = 0;
    out_ready = 0;
    pixel_x = 0;
    pixel_y = 0;
    red_in = 0;
    green_in = 0;
    blue_in = 0;
    cfg_write = 0;
    cfg_index = REG_CENTER_X;
    cfg_data = 0;
    cen_x = 32768;
    cen_y = 32768;
    amount = 8'hCE;
    roundness = 0;
    softness = 50;
    tint = 0;
    width = 1920;
    height = 1080;
    repeat (2) @(posedge clk);
    rst <= 0;

    // directed: defaults, corners and center, extreme channels
    add_pixel(0, 0, 255, 255, 255);
    add_pixel(960, 540, 255, 0, 128);
    add_pixel(1919, 1079, 0, 255, 1);
    add_pixel(4095, 4095, 170, 85, 255);
    add_pixel(4095, 0, 0, 0, 0);
    add_pixel(0, 4095, 255, 255, 255);
    run_phase();

    // zero amount gives the tint; odd frame sizes clamp
    write_reg(REG_AMOUNT, 0);
    write_reg(REG_TINT, 24'hFFFFFF);
    write_reg(REG_WIDTH, 0);
    write_reg(REG_HEIGHT, 13'h1FFF);
    add_pixel(0, 0, 12, 34, 56);
    add_pixel(4095, 4095, 255, 0, 255);
    add_pixel(2048, 100, 0, 0, 0);
    run_phase();

    // flat ellipse, out-of-range percents, extreme centers and softness
    write_reg(REG_ROUNDNESS, 8'h80);
    write_reg(REG_AMOUNT, 8'h7F);
    write_reg(REG_CENTER_X, 0);
    write_reg(REG_CENTER_Y, 16'hFFFF);
    write_reg(REG_SOFTNESS, 7'h7F);
    write_reg(REG_WIDTH, 1);
    write_reg(REG_HEIGHT, 4096);
    add_pixel(0, 0, 200, 100, 50);
    add_pixel(4095, 4095, 1, 2, 3);
    run_phase();
    write_reg(REG_ROUNDNESS, 100);
    write_reg(REG_AMOUNT, 8'h80);
    write_reg(REG_SOFTNESS, 0);
    write_reg(REG_TINT, 24'h123456);
    add_pixel(0, 0, 255, 255, 255);
    add_pixel(4095, 4095, 255, 255, 255);
    add_pixel(0, 4095, 99, 0, 200);
    write_reg(REG_WIDTH, 1920);
    run_phase();

    // random phases
    repeat (9) begin
      write_reg(REG_CENTER_X, $urandom_range(0, 65535));
      write_reg(REG_CENTER_Y, $urandom_range(0, 65535));
      write_reg(REG_AMOUNT, $urandom_range(0, 9) == 0 ? $urandom_range(0, 255)
                                                      : (($urandom_range(0, 200) - 100) & 255));
      write_reg(REG_ROUNDNESS, $urandom_range(0, 9) == 0 ? $urandom_range(0, 255)
                                                         : (($urandom_range(0, 199) - 99) & 255));
      write_reg(REG_SOFTNESS, $urandom_range(0, 9) == 0 ? $urandom_range(0, 127)
                                                        : $urandom_range(0, 100));
      write_reg(REG_TINT, $urandom_range(0, 24'hFFFFFF));
      w = $urandom_range(0, 3) == 0 ? $urandom_range(1, 4096) : $urandom_range(16, 800);
      h = $urandom_range(0, 3) == 0 ? $urandom_range(1, 4096) : $urandom_range(16, 800);
      write_reg(REG_WIDTH, $urandom_range(0, 19) == 0 ? $urandom_range(0, 8191) : w);
      write_reg(REG_HEIGHT, $urandom_range(0, 19) == 0 ? $urandom_range(0, 8191) : h);
      add_random(150, w, h);
      run_phase();
    end

    if (errors == 0) begin
      $display("radial_vignette_blend_unit: match");
    end else begin
      $display("radial_vignette_blend_unit: mismatch");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("radial_vignette_blend_unit: mismatch");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/rvb_pkg.sv
rtl/rvb_div_pipe.sv
rtl/rvb_sqrt_pipe.sv
rtl/radial_vignette_blend_unit.sv
test/radial_vignette_blend_unit_test.sv
